>>> src/vbd_pkg.sv
// vbd_pkg: shared constants, register indexes and types of the volume block downsampler
// depends on nothing; used by volume_block_downsampler
package vbd_pkg;

    localparam int MAX_PLANE_DIM_DEF = 256;
    localparam int MAX_FACTOR_DEF    = 16;

    localparam int VOX_W       = 8;
    localparam int OXY_W       = 8;
    localparam int OZ_W        = 10;
    localparam int SUM_W       = 20;
    localparam int FACTOR_W    = 5;
    localparam int DIM_W       = 9;
    localparam int DEPTH_W     = 11;
    localparam int PZ_W        = 10;
    localparam int DEPTH_LIMIT = 1024;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [FACTOR_W-1:0] FACTOR_RST    = 5'd4;
    localparam logic                PICK_MODE_RST = 1'b0;
    localparam logic [DIM_W-1:0]    IN_WIDTH_RST  = 9'd256;
    localparam logic [DIM_W-1:0]    IN_HEIGHT_RST = 9'd256;
    localparam logic [DEPTH_W-1:0]  IN_DEPTH_RST  = 11'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACTOR    = 3'd0,
        CFG_PICK_MODE = 3'd1,
        CFG_IN_WIDTH  = 3'd2,
        CFG_IN_HEIGHT = 3'd3,
        CFG_IN_DEPTH  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLAMP,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_LOAD,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [OXY_W-1:0] x;
        logic [OXY_W-1:0] y;
        logic [OZ_W-1:0]  z;
        logic             last;
    } t_meta;

endpackage

>>> src/vbd_ram.sv
// vbd_ram: generic single write port, single read port ram with registered read
// read returns the old word when read and write hit the same address; no dependencies
module vbd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/volume_block_downsampler.sv
// volume_block_downsampler: 3d box-filter/pick decimator, block sums in one plane ram (vbd_ram, vbd_pkg)
// one voxel per cycle barring setup, clearing, output stalls; results go through b, c1, c2, c3, out
// rate is set by the single read-modify-write of the plane ram, forwarded between back-to-back beats
// after reset all MAX_PLANE_DIM*MAX_PLANE_DIM plane ram words are cleared, no voxel taken meanwhile
// after reset and each config write the setup (clamp, mul, div, load) rebuilds the divided sizes
// reset is synchronous, active low; config registers return to their reset values
module volume_block_downsampler #(
    parameter int MAX_PLANE_DIM = vbd_pkg::MAX_PLANE_DIM_DEF,
    parameter int MAX_FACTOR    = vbd_pkg::MAX_FACTOR_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [vbd_pkg::VOX_W-1:0]       i_voxel,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [vbd_pkg::VOX_W-1:0]       o_value,
    output logic [vbd_pkg::OXY_W-1:0]       o_out_x,
    output logic [vbd_pkg::OXY_W-1:0]       o_out_y,
    output logic [vbd_pkg::OZ_W-1:0]        o_out_z,
    output logic                            o_last
);

    localparam int SUM_W     = vbd_pkg::SUM_W;
    localparam int PZ_W      = vbd_pkg::PZ_W;
    localparam int DEPTH_W   = vbd_pkg::DEPTH_W;
    localparam int VOX_W     = vbd_pkg::VOX_W;
    localparam int PX_W      = $clog2(MAX_PLANE_DIM);
    localparam int PD_W      = $clog2(MAX_PLANE_DIM + 1);
    localparam int RAM_DEPTH = MAX_PLANE_DIM * MAX_PLANE_DIM;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int FF_W      = $clog2(MAX_FACTOR + 1);
    localparam int RX_W      = $clog2(MAX_FACTOR);
    localparam int D_W       = 3 * FF_W;
    localparam int DIV_W     = SUM_W + 1;
    localparam int RQ_W      = D_W + DIV_W;
    localparam int STEP_W    = $clog2(DIV_W);
    localparam int PROD_W    = SUM_W + DIV_W;
    localparam int QW        = SUM_W + D_W;
    localparam int NLANE     = 7;
    localparam int LN_W      = 0;
    localparam int LN_H      = 1;
    localparam int LN_D      = 2;
    localparam int LN_X      = 3;
    localparam int LN_Y      = 4;
    localparam int LN_Z      = 5;
    localparam int LN_M      = 6;

    // one restoring division step: remainder on top, dividend shifting into quotient below
    function automatic logic [RQ_W-1:0] div_step(input logic [RQ_W-1:0] rq,
                                                 input logic [D_W-1:0] dv);
        logic [RQ_W:0] s;
        logic [D_W:0]  top;
        logic          qb;
        s   = {rq, 1'b0};
        top = s[RQ_W:DIV_W];
        qb  = 1'b0;
        if (top >= {1'b0, dv}) begin
            top = top - {1'b0, dv};
            qb  = 1'b1;
        end
        return {top[D_W-1:0], s[DIV_W-1:1], qb};
    endfunction

    // config registers
    logic [vbd_pkg::FACTOR_W-1:0] r_factor;
    logic                         r_pick;
    logic [vbd_pkg::DIM_W-1:0]    r_in_width;
    logic [vbd_pkg::DIM_W-1:0]    r_in_height;
    logic [DEPTH_W-1:0]           r_in_depth;

    vbd_pkg::t_state r_state, n_state;

    // setup
    logic [FF_W-1:0]   r_f;
    logic [PD_W-1:0]   r_w, r_h;
    logic [DEPTH_W-1:0] r_d;
    logic [2*FF_W-1:0] r_f2;
    logic [D_W-1:0]    r_dd;
    logic [RQ_W-1:0]   r_lane [NLANE];
    logic [STEP_W-1:0] r_step;
    logic [PD_W-1:0]   r_ow, r_oh;
    logic [DEPTH_W-1:0] r_od;
    logic [DIV_W-1:0]  r_m;

    // position and block counters
    logic [PX_W-1:0]   r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [PZ_W-1:0]   r_pos_z, n_pos_z;
    logic [PX_W-1:0]   r_bx, r_by, n_bx, n_by;
    logic [PZ_W-1:0]   r_bz, n_bz;
    logic [RX_W-1:0]   r_rx, r_ry, r_rz, n_rx, n_ry, n_rz;
    logic [ADDR_W-1:0] r_base, n_base;

    // ram clearing
    logic              r_clr;
    logic [ADDR_W-1:0] r_clr_addr;

    // read-modify-write stage
    logic                 r_b_v, r_b_blk, r_b_first, r_b_fin;
    logic [ADDR_W-1:0]    r_b_idx;
    logic [VOX_W-1:0]     r_b_vox;
    vbd_pkg::t_meta       r_b_meta;
    logic                 r_fwd_hit;
    logic [SUM_W-1:0]     r_fwd_data;

    // divide stages
    logic                 r_c1_v, r_c2_v, r_c3_v, r_out_v;
    logic [SUM_W-1:0]     r_c1_acc, r_c2_acc, r_c3_acc;
    logic [PROD_W-1:0]    r_c2_prod;
    logic [SUM_W-1:0]     r_c3_q0, r_c3_qd;
    vbd_pkg::t_meta       r_c1_meta, r_c2_meta, r_c3_meta, r_out_meta;
    logic [VOX_W-1:0]     r_out_value;

    logic              cfg_acc, in_acc;
    logic              out_free, c3_ok, c2_ok, c1_ok, b_free;
    logic              f_zero, x_more, y_more, z_more, rx_end, ry_end, rz_end;
    logic              a_blk, a_first, a_final, a_last;
    logic [ADDR_W-1:0] a_idx;
    vbd_pkg::t_meta    a_meta;
    logic [SUM_W-1:0]  ram_rd_data, b_rd, b_acc;
    logic              b_wr;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [SUM_W-1:0]  ram_wr_data;
    logic [SUM_W-1:0]  q0, rem, q_fix;
    logic [VOX_W-1:0]  out_value;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor    <= vbd_pkg::FACTOR_RST;
            r_pick      <= vbd_pkg::PICK_MODE_RST;
            r_in_width  <= vbd_pkg::IN_WIDTH_RST;
            r_in_height <= vbd_pkg::IN_HEIGHT_RST;
            r_in_depth  <= vbd_pkg::IN_DEPTH_RST;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                vbd_pkg::CFG_FACTOR:    r_factor    <= i_cfg_data[vbd_pkg::FACTOR_W-1:0];
                vbd_pkg::CFG_PICK_MODE: r_pick      <= i_cfg_data[0];
                vbd_pkg::CFG_IN_WIDTH:  r_in_width  <= i_cfg_data[vbd_pkg::DIM_W-1:0];
                vbd_pkg::CFG_IN_HEIGHT: r_in_height <= i_cfg_data[vbd_pkg::DIM_W-1:0];
                vbd_pkg::CFG_IN_DEPTH:  r_in_depth  <= i_cfg_data[DEPTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // setup sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vbd_pkg::ST_CLAMP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vbd_pkg::ST_CLAMP: n_state = vbd_pkg::ST_MUL1;
            vbd_pkg::ST_MUL1:  n_state = vbd_pkg::ST_MUL2;
            vbd_pkg::ST_MUL2:  n_state = vbd_pkg::ST_DIV;
            vbd_pkg::ST_DIV: begin
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    n_state = vbd_pkg::ST_LOAD;
                end
            end
            vbd_pkg::ST_LOAD:  n_state = vbd_pkg::ST_RUN;
            vbd_pkg::ST_RUN:   n_state = vbd_pkg::ST_RUN;
            default:           n_state = vbd_pkg::ST_CLAMP;
        endcase
        if (cfg_acc) begin
            n_state = vbd_pkg::ST_CLAMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == vbd_pkg::ST_CLAMP) begin
            r_f <= (int'(r_factor) > MAX_FACTOR) ? FF_W'(MAX_FACTOR) : FF_W'(r_factor);
            r_w <= (int'(r_in_width) > MAX_PLANE_DIM) ? PD_W'(MAX_PLANE_DIM)
                                                       : PD_W'(r_in_width);
            r_h <= (int'(r_in_height) > MAX_PLANE_DIM) ? PD_W'(MAX_PLANE_DIM)
                                                        : PD_W'(r_in_height);
            r_d <= (int'(r_in_depth) > vbd_pkg::DEPTH_LIMIT) ? DEPTH_W'(vbd_pkg::DEPTH_LIMIT)
                                                              : r_in_depth;
        end
        if (r_state == vbd_pkg::ST_MUL1) begin
            r_f2 <= (2 * FF_W)'(r_f) * (2 * FF_W)'(r_f);
        end
        if (r_state == vbd_pkg::ST_MUL2) begin
            r_dd         <= D_W'(r_f2) * D_W'(r_f);
            r_step       <= '0;
            r_lane[LN_W] <= {{D_W{1'b0}}, DIV_W'(r_w)};
            r_lane[LN_H] <= {{D_W{1'b0}}, DIV_W'(r_h)};
            r_lane[LN_D] <= {{D_W{1'b0}}, DIV_W'(r_d)};
            r_lane[LN_X] <= {{D_W{1'b0}}, DIV_W'(r_pos_x)};
            r_lane[LN_Y] <= {{D_W{1'b0}}, DIV_W'(r_pos_y)};
            r_lane[LN_Z] <= {{D_W{1'b0}}, DIV_W'(r_pos_z)};
            r_lane[LN_M] <= {{D_W{1'b0}}, 1'b1, {SUM_W{1'b0}}};
        end
        if (r_state == vbd_pkg::ST_DIV) begin
            r_step <= r_step + 1'b1;
            for (int i = 0; i < NLANE; i++) begin
                r_lane[i] <= div_step(r_lane[i], (i == LN_M) ? r_dd : D_W'(r_f));
            end
        end
        if (r_state == vbd_pkg::ST_LOAD) begin
            r_ow <= r_lane[LN_W][PD_W-1:0];
            r_oh <= r_lane[LN_H][PD_W-1:0];
            r_od <= r_lane[LN_D][DEPTH_W-1:0];
            r_m  <= r_lane[LN_M][DIV_W-1:0];
        end
    end

    // accept-side decode from the counters
    assign f_zero = (r_f == '0);
    assign x_more = (PD_W'(r_pos_x) + 1'b1) < r_w;
    assign y_more = (PD_W'(r_pos_y) + 1'b1) < r_h;
    assign z_more = (DEPTH_W'(r_pos_z) + 1'b1) < r_d;
    assign rx_end = ((FF_W + 1)'(r_rx) + 1'b1) == (FF_W + 1)'(r_f);
    assign ry_end = ((FF_W + 1)'(r_ry) + 1'b1) == (FF_W + 1)'(r_f);
    assign rz_end = ((FF_W + 1)'(r_rz) + 1'b1) == (FF_W + 1)'(r_f);

    assign a_blk   = !f_zero && (PD_W'(r_bx) < r_ow) && (PD_W'(r_by) < r_oh)
                     && (DEPTH_W'(r_bz) < r_od);
    assign a_first = (r_rx == '0) && (r_ry == '0) && (r_rz == '0);
    assign a_final = rx_end && ry_end && rz_end;
    assign a_last  = ((PD_W'(r_bx) + 1'b1) == r_ow) && ((PD_W'(r_by) + 1'b1) == r_oh)
                     && ((DEPTH_W'(r_bz) + 1'b1) == r_od);
    assign a_idx   = r_base + ADDR_W'(r_bx);

    always_comb begin
        a_meta.x    = vbd_pkg::OXY_W'(r_bx);
        a_meta.y    = vbd_pkg::OXY_W'(r_by);
        a_meta.z    = vbd_pkg::OZ_W'(r_bz);
        a_meta.last = a_last;
    end

    // handshake and stage flow
    assign out_free = !r_out_v || i_out_ready;
    assign c3_ok    = !r_c3_v || out_free;
    assign c2_ok    = !r_c2_v || c3_ok;
    assign c1_ok    = !r_c1_v || c2_ok;
    assign b_free   = !r_b_v || !r_b_fin || c1_ok;

    assign o_in_ready = (r_state == vbd_pkg::ST_RUN) && !r_clr && b_free;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        n_bx    = r_bx;
        n_by    = r_by;
        n_bz    = r_bz;
        n_rx    = r_rx;
        n_ry    = r_ry;
        n_rz    = r_rz;
        n_base  = r_base;
        if (r_state == vbd_pkg::ST_LOAD) begin
            n_bx   = r_lane[LN_X][PX_W-1:0];
            n_by   = r_lane[LN_Y][PX_W-1:0];
            n_bz   = r_lane[LN_Z][PZ_W-1:0];
            n_rx   = r_lane[LN_X][DIV_W +: RX_W];
            n_ry   = r_lane[LN_Y][DIV_W +: RX_W];
            n_rz   = r_lane[LN_Z][DIV_W +: RX_W];
            n_base = ADDR_W'(ADDR_W'(r_lane[LN_Y][PX_W-1:0]) * ADDR_W'(r_lane[LN_W][PD_W-1:0]));
        end else if (in_acc) begin
            if (x_more) begin
                n_pos_x = r_pos_x + 1'b1;
                if (rx_end) begin
                    n_rx = '0;
                    n_bx = r_bx + 1'b1;
                end else begin
                    n_rx = r_rx + 1'b1;
                end
            end else begin
                n_pos_x = '0;
                n_rx    = '0;
                n_bx    = '0;
                if (y_more) begin
                    n_pos_y = r_pos_y + 1'b1;
                    if (ry_end) begin
                        n_ry   = '0;
                        n_by   = r_by + 1'b1;
                        n_base = r_base + ADDR_W'(r_ow);
                    end else begin
                        n_ry = r_ry + 1'b1;
                    end
                end else begin
                    n_pos_y = '0;
                    n_ry    = '0;
                    n_by    = '0;
                    n_base  = '0;
                    if (z_more) begin
                        n_pos_z = r_pos_z + 1'b1;
                        if (rz_end) begin
                            n_rz = '0;
                            n_bz = r_bz + 1'b1;
                        end else begin
                            n_rz = r_rz + 1'b1;
                        end
                    end else begin
                        n_pos_z = '0;
                        n_rz    = '0;
                        n_bz    = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_bx    <= '0;
            r_by    <= '0;
            r_bz    <= '0;
            r_rx    <= '0;
            r_ry    <= '0;
            r_rz    <= '0;
            r_base  <= '0;
        end else begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
            r_bx    <= n_bx;
            r_by    <= n_by;
            r_bz    <= n_bz;
            r_rx    <= n_rx;
            r_ry    <= n_ry;
            r_rz    <= n_rz;
            r_base  <= n_base;
        end
    end

    // clearing pass over the plane ram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(RAM_DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    // read-modify-write
    assign b_rd  = r_fwd_hit ? r_fwd_data : ram_rd_data;
    assign b_acc = r_b_first ? SUM_W'(r_b_vox)
                 : (!r_pick ? b_rd + SUM_W'(r_b_vox) : b_rd);
    assign b_wr  = r_b_v && r_b_blk && b_free;

    assign ram_wr_en   = r_clr || b_wr;
    assign ram_wr_addr = r_clr ? r_clr_addr : r_b_idx;
    assign ram_wr_data = r_clr ? '0 : b_acc;

    vbd_ram #(
        .DATA_W (SUM_W),
        .DEPTH  (RAM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (b_free),
        .i_rd_addr (a_idx),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (b_free) begin
            r_b_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free) begin
            r_b_blk    <= a_blk;
            r_b_first  <= a_first;
            r_b_fin    <= a_blk && a_final;
            r_b_idx    <= a_idx;
            r_b_vox    <= i_voxel;
            r_b_meta   <= a_meta;
            // same entry written this cycle: the read just issued sees the old word
            r_fwd_hit  <= b_wr && (a_idx == r_b_idx);
            r_fwd_data <= b_acc;
        end
    end

    // mean by reciprocal multiply and one correction step; pick mode passes the block's first voxel
    assign q0    = r_c3_q0;
    assign rem   = r_c3_acc - r_c3_qd;
    assign q_fix = (QW'(rem) >= QW'(r_dd)) ? q0 + 1'b1 : q0;
    assign out_value = r_pick ? r_c3_acc[VOX_W-1:0] : q_fix[VOX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v  <= 1'b0;
            r_c2_v  <= 1'b0;
            r_c3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (c1_ok) begin
                r_c1_v <= r_b_v && r_b_fin;
            end
            if (c2_ok) begin
                r_c2_v <= r_c1_v;
            end
            if (c3_ok) begin
                r_c3_v <= r_c2_v;
            end
            if (out_free) begin
                r_out_v <= r_c3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c1_ok) begin
            r_c1_acc  <= b_acc;
            r_c1_meta <= r_b_meta;
        end
        if (c2_ok) begin
            r_c2_acc  <= r_c1_acc;
            r_c2_prod <= PROD_W'(r_c1_acc) * PROD_W'(r_m);
            r_c2_meta <= r_c1_meta;
        end
        if (c3_ok) begin
            r_c3_acc  <= r_c2_acc;
            r_c3_q0   <= r_c2_prod[SUM_W +: SUM_W];
            r_c3_qd   <= SUM_W'(QW'(r_c2_prod[SUM_W +: SUM_W]) * QW'(r_dd));
            r_c3_meta <= r_c2_meta;
        end
        if (out_free && r_c3_v) begin
            r_out_value <= out_value;
            r_out_meta  <= r_c3_meta;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_value     = r_out_value;
    assign o_out_x     = r_out_meta.x;
    assign o_out_y     = r_out_meta.y;
    assign o_out_z     = r_out_meta.z;
    assign o_last      = r_out_meta.last;

endmodule
